// ===== design/dljs_pkg.sv =====
// Shared types and constants for the delay, jitter and loss statistics core.
// No dependencies; used by dljs_arith_unit, delay_jitter_loss_statistics_core and the test files.
package dljs_pkg;

   localparam int DELAY_BITS = 22;
   localparam int COUNT_BITS = 20;
   localparam int TIME_BITS  = 48;
   localparam int SUM_BITS   = DELAY_BITS + COUNT_BITS;
   localparam int SQ_BITS    = 64;
   localparam int WIDE_BITS  = 128;
   localparam int STEP_COUNT = 64;
   localparam int STEP_BITS  = $clog2(STEP_COUNT);

   localparam logic [DELAY_BITS-1:0] DELAY_MAX = {DELAY_BITS{1'b1}};
   localparam logic [COUNT_BITS-1:0] COUNT_MAX = {COUNT_BITS{1'b1}};
   localparam logic [21:0]           DEV_MAX   = 22'h3FFFFF;
   localparam logic [15:0]           PAYLOAD_RESET  = 16'd64;
   localparam logic [31:0]           INTERVAL_RESET = 32'd1000000;
   localparam logic [13:0]           LOSS_SCALE     = 14'd10000;

   // Request codes; the two remaining codes are time polls.
   localparam logic [1:0] REQ_PROBE = 2'd0;
   localparam logic [1:0] REQ_REPLY = 2'd1;

   // Configuration register indexes.
   localparam logic CSR_PAYLOAD_BYTES   = 1'b0;
   localparam logic CSR_REPORT_INTERVAL = 1'b1;

   typedef struct packed {
      logic [1:0]           req_type;
      logic [TIME_BITS-1:0] now_us;
      logic [TIME_BITS-1:0] stamp_us;
   } dljs_req_type;

   typedef struct packed {
      logic [DELAY_BITS-1:0] delay_mean;
      logic [21:0]           delay_dev;
      logic [41:0]           jitter_mean;
      logic [21:0]           jitter_dev;
      logic [13:0]           loss_centi_pct;
      logic [38:0]           window_bits;
      logic [COUNT_BITS-1:0] window_sent;
      logic [COUNT_BITS-1:0] window_rcvd;
      logic [31:0]           running_sent;
      logic [31:0]           running_rcvd;
   } dljs_rsp_type;

   typedef enum logic [1:0] {
      OP_MUL,
      OP_DIV,
      OP_SQRT
   } dljs_op_type;

   typedef struct packed {
      logic                 start;
      dljs_op_type          op;
      logic [WIDE_BITS-1:0] operand_a;
      logic [63:0]          operand_b;
   } dljs_cmd_type;

   typedef struct packed {
      logic                 done;
      logic [WIDE_BITS-1:0] result;
   } dljs_res_type;

   typedef enum logic [4:0] {
      ST_IDLE,
      ST_SQD,
      ST_SQJ,
      ST_CHECK,
      ST_DMEAN,
      ST_DNS2,
      ST_DS1S1,
      ST_DSQRT,
      ST_DDEV,
      ST_JMEAN,
      ST_JMS2,
      ST_JS1S1,
      ST_JSQRT,
      ST_JDEV,
      ST_LOSS,
      ST_DONE
   } dljs_state_type;

endpackage

// ===== design/dljs_arith_unit.sv =====
// Shared bit-serial arithmetic unit: multiply, divide and square root.
// Depends on dljs_pkg. Each operation takes 64 steps, one bit (two for root) a cycle.
module dljs_arith_unit
   import dljs_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  dljs_cmd_type cmd,
   output dljs_res_type res
);

   logic                 busy_ff;
   logic                 done_ff;
   logic [STEP_BITS-1:0] count_ff;
   dljs_op_type          op_ff;
   logic [WIDE_BITS-1:0] acc_ff, acc_in;
   logic [WIDE_BITS-1:0] aux_ff, aux_in;
   logic [63:0]          opb_ff, opb_in;

   logic [64:0] div_rem;
   logic        div_ge;
   logic [67:0] sqrt_rem;
   logic [67:0] sqrt_trial;
   logic        sqrt_ge;

   // Trial values for one divide step and one root step.
   always_comb begin
      div_rem    = {aux_ff[63:0], acc_ff[63]};
      div_ge     = div_rem >= {1'b0, opb_ff};
      sqrt_rem   = {aux_ff[65:0], acc_ff[WIDE_BITS-1 -: 2]};
      sqrt_trial = {2'b00, opb_ff, 2'b01};
      sqrt_ge    = sqrt_rem >= sqrt_trial;
   end

   // Operand load on start, otherwise, while busy, one step of the current operation.
   always_comb begin
      acc_in = acc_ff;
      aux_in = aux_ff;
      opb_in = opb_ff;
      if (cmd.start) begin
         unique case (cmd.op)
            OP_MUL: begin
               acc_in = '0;
               aux_in = {64'd0, cmd.operand_a[63:0]};
               opb_in = cmd.operand_b;
            end
            OP_DIV: begin
               acc_in = {64'd0, cmd.operand_a[63:0]};
               aux_in = '0;
               opb_in = cmd.operand_b;
            end
            default: begin
               acc_in = cmd.operand_a;
               aux_in = '0;
               opb_in = '0;
            end
         endcase
      end else if (busy_ff) begin
         unique case (op_ff)
            OP_MUL: begin
               if (opb_ff[0]) begin
                  acc_in = acc_ff + aux_ff;
               end
               aux_in = {aux_ff[WIDE_BITS-2:0], 1'b0};
               opb_in = {1'b0, opb_ff[63:1]};
            end
            OP_DIV: begin
               aux_in = div_ge ? {63'd0, div_rem - {1'b0, opb_ff}} : {63'd0, div_rem};
               acc_in = {64'd0, acc_ff[62:0], div_ge};
            end
            default: begin
               aux_in = sqrt_ge ? {60'd0, sqrt_rem - sqrt_trial} : {60'd0, sqrt_rem};
               opb_in = {opb_ff[62:0], sqrt_ge};
               acc_in = {acc_ff[WIDE_BITS-3:0], 2'b00};
            end
         endcase
      end
   end

   // Step control.
   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff  <= 1'b0;
         done_ff  <= 1'b0;
         count_ff <= '0;
         op_ff    <= OP_MUL;
      end else begin
         done_ff <= 1'b0;
         if (cmd.start) begin
            busy_ff  <= 1'b1;
            count_ff <= '0;
            op_ff    <= cmd.op;
         end else if (busy_ff) begin
            count_ff <= count_ff + 1'b1;
            if (count_ff == STEP_BITS'(STEP_COUNT - 1)) begin
               busy_ff <= 1'b0;
               done_ff <= 1'b1;
            end
         end
      end
   end

   // Working registers.
   always_ff @(posedge clock) begin
      acc_ff <= acc_in;
      aux_ff <= aux_in;
      opb_ff <= opb_in;
   end

   // Result selection.
   always_comb begin
      res.done = done_ff;
      unique case (op_ff)
         OP_MUL:  res.result = acc_ff;
         OP_DIV:  res.result = {64'd0, acc_ff[63:0]};
         default: res.result = {64'd0, opb_ff};
      endcase
   end

endmodule

// ===== design/delay_jitter_loss_statistics_core.sv =====
// Delay, jitter and loss statistics core: sequencer, window state and output register.
// Depends on dljs_pkg and dljs_arith_unit.
// Each state that uses the shared bit-serial unit holds until the unit signals done. A
// reply first runs its two squarings; a probe or poll goes straight to the report check. A
// report adds at most eleven operations and the output load, which waits while an earlier
// report is still stalled. One transaction is worked at a time.
// Reset is synchronous: statistics clear, registers return to their defaults.
module delay_jitter_loss_statistics_core
   import dljs_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  logic         req_valid,
   output logic         req_stall,
   input  dljs_req_type req_data,
   output logic         rsp_valid,
   input  logic         rsp_stall,
   output dljs_rsp_type rsp_data,
   input  logic         csr_valid,
   output logic         csr_ready,
   input  logic         csr_index,
   input  logic [31:0]  csr_wdata
);

   dljs_state_type state_ff, state_in;

   logic [15:0]           payload_ff;
   logic [31:0]           interval_ff;
   logic [COUNT_BITS-1:0] sent_ff, rcvd_ff;
   logic [SUM_BITS-1:0]   dtot_ff, jtot_ff;
   logic [SQ_BITS-1:0]    dsq_ff, jsq_ff;
   logic [DELAY_BITS-1:0] prev_ff;
   logic [TIME_BITS-1:0]  next_rpt_ff;
   logic                  armed_ff;
   logic [31:0]           sent_grand_ff, rcvd_grand_ff;

   logic [TIME_BITS-1:0]  now_ff;
   logic [DELAY_BITS-1:0] d_ff, j_ff;
   logic                  sq_ok_ff;
   logic [WIDE_BITS-1:0]  prod_ff;
   logic [63:0]           root_ff;
   logic [DELAY_BITS-1:0] dm_ff;
   logic [21:0]           dd_ff, jd_ff;
   logic [41:0]           jm_ff;
   logic [13:0]           loss_ff;
   logic                  launched_ff;
   logic                  rsp_valid_ff;
   dljs_rsp_type          rsp_data_ff;

   dljs_cmd_type cmd;
   dljs_res_type res;

   logic                  req_accept;
   logic [TIME_BITS-1:0]  round_trip;
   logic [DELAY_BITS-1:0] d_new, j_new;
   logic [COUNT_BITS-1:0] m_cnt;
   logic [TIME_BITS-1:0]  since_rpt;
   logic                  due;
   logic                  need_loss;
   logic [33:0]           loss_num;
   logic [35:0]           win_bytes;
   logic                  res_le_prod;
   logic                  load_ok;
   logic                  op_state;
   logic [SQ_BITS:0]      sq_sum;

   dljs_arith_unit u_arith (
      .clock (clock),
      .reset (reset),
      .cmd   (cmd),
      .res   (res)
   );

   // Per-transaction arithmetic around the shared unit.
   always_comb begin
      req_accept  = req_valid && (state_ff == ST_IDLE);
      round_trip  = req_data.now_us - req_data.stamp_us;
      d_new       = (|round_trip[TIME_BITS-1:DELAY_BITS]) ? DELAY_MAX
                                                          : round_trip[DELAY_BITS-1:0];
      j_new       = (d_new >= prev_ff) ? d_new - prev_ff : prev_ff - d_new;
      m_cnt       = (rcvd_ff >= COUNT_BITS'(2)) ? rcvd_ff - 1'b1 : COUNT_BITS'(1);
      since_rpt   = now_ff - next_rpt_ff;
      due         = !since_rpt[TIME_BITS-1];
      need_loss   = (sent_ff != '0) && (sent_ff > rcvd_ff);
      loss_num    = 34'(LOSS_SCALE) * 34'(sent_ff - rcvd_ff);
      win_bytes   = 36'(payload_ff) * 36'(rcvd_ff);
      res_le_prod = res.result <= prod_ff;
      load_ok     = !rsp_valid_ff || !rsp_stall;
      sq_sum      = (state_ff == ST_SQD) ? {1'b0, dsq_ff} + {1'b0, res.result[SQ_BITS-1:0]}
                                         : {1'b0, jsq_ff} + {1'b0, res.result[SQ_BITS-1:0]};
   end

   // Next state.
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE:  if (req_valid) begin
                      state_in = (req_data.req_type == REQ_REPLY) ? ST_SQD : ST_CHECK;
                   end
         ST_SQD:   if (res.done) state_in = ST_SQJ;
         ST_SQJ:   if (res.done) state_in = ST_CHECK;
         ST_CHECK: begin
            if (!due) begin
               state_in = ST_IDLE;
            end else if (rcvd_ff == '0) begin
               state_in = ST_LOSS;
            end else begin
               state_in = ST_DMEAN;
            end
         end
         ST_DMEAN: if (res.done) state_in = ST_DNS2;
         ST_DNS2:  if (res.done) state_in = ST_DS1S1;
         ST_DS1S1: if (res.done) state_in = res_le_prod ? ST_DSQRT : ST_JMEAN;
         ST_DSQRT: if (res.done) state_in = ST_DDEV;
         ST_DDEV:  if (res.done) state_in = ST_JMEAN;
         ST_JMEAN: if (res.done) state_in = ST_JMS2;
         ST_JMS2:  if (res.done) state_in = ST_JS1S1;
         ST_JS1S1: if (res.done) state_in = ST_JSQRT;
         ST_JSQRT: if (res.done) state_in = ST_JDEV;
         ST_JDEV:  if (res.done) state_in = ST_LOSS;
         ST_LOSS:  if (!need_loss || res.done) state_in = ST_DONE;
         ST_DONE:  if (load_ok) state_in = ST_IDLE;
         default:  state_in = ST_IDLE;
      endcase
   end

   // Unit commands for each state.
   always_comb begin
      op_state      = 1'b1;
      cmd.op        = OP_MUL;
      cmd.operand_a = '0;
      cmd.operand_b = '0;
      unique case (state_ff)
         ST_SQD: begin
            cmd.operand_a = WIDE_BITS'(d_ff);
            cmd.operand_b = 64'(d_ff);
         end
         ST_SQJ: begin
            cmd.operand_a = WIDE_BITS'(j_ff);
            cmd.operand_b = 64'(j_ff);
         end
         ST_DMEAN: begin
            cmd.op        = OP_DIV;
            cmd.operand_a = WIDE_BITS'(dtot_ff);
            cmd.operand_b = 64'(rcvd_ff);
         end
         ST_DNS2: begin
            cmd.operand_a = WIDE_BITS'(rcvd_ff);
            cmd.operand_b = dsq_ff;
         end
         ST_DS1S1: begin
            cmd.operand_a = WIDE_BITS'(dtot_ff);
            cmd.operand_b = 64'(dtot_ff);
         end
         ST_DSQRT, ST_JSQRT: begin
            cmd.op        = OP_SQRT;
            cmd.operand_a = prod_ff;
         end
         ST_DDEV: begin
            cmd.op        = OP_DIV;
            cmd.operand_a = WIDE_BITS'(root_ff);
            cmd.operand_b = 64'(rcvd_ff);
         end
         ST_JMEAN: begin
            cmd.op        = OP_DIV;
            cmd.operand_a = WIDE_BITS'(jtot_ff);
            cmd.operand_b = 64'(m_cnt);
         end
         ST_JMS2: begin
            cmd.operand_a = WIDE_BITS'(m_cnt);
            cmd.operand_b = jsq_ff;
         end
         ST_JS1S1: begin
            cmd.operand_a = WIDE_BITS'(jtot_ff);
            cmd.operand_b = 64'(jtot_ff);
         end
         ST_JDEV: begin
            cmd.op        = OP_DIV;
            cmd.operand_a = WIDE_BITS'(root_ff);
            cmd.operand_b = 64'(m_cnt);
         end
         ST_LOSS: begin
            op_state      = need_loss;
            cmd.op        = OP_DIV;
            cmd.operand_a = WIDE_BITS'(loss_num);
            cmd.operand_b = 64'(sent_ff);
         end
         default: op_state = 1'b0;
      endcase
      cmd.start = op_state && !launched_ff;
   end

   // Window statistics, sequencing results and the output register.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         payload_ff    <= PAYLOAD_RESET;
         interval_ff   <= INTERVAL_RESET;
         sent_ff       <= '0;
         rcvd_ff       <= '0;
         dtot_ff       <= '0;
         jtot_ff       <= '0;
         dsq_ff        <= '0;
         jsq_ff        <= '0;
         prev_ff       <= '0;
         next_rpt_ff   <= '0;
         armed_ff      <= 1'b0;
         sent_grand_ff <= '0;
         rcvd_grand_ff <= '0;
         launched_ff   <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff <= state_in;

         // Configuration writes.
         if (csr_valid && csr_ready) begin
            unique case (csr_index)
               CSR_PAYLOAD_BYTES:   payload_ff  <= csr_wdata[15:0];
               CSR_REPORT_INTERVAL: interval_ff <= csr_wdata;
               default:             interval_ff <= csr_wdata;
            endcase
         end

         // Unit launch tracking.
         if (cmd.start) begin
            launched_ff <= 1'b1;
         end else if (res.done) begin
            launched_ff <= 1'b0;
         end

         // Output handshake.
         if (rsp_valid_ff && !rsp_stall) begin
            rsp_valid_ff <= 1'b0;
         end

         // Transaction acceptance: counters, sums and timer arming.
         if (req_accept) begin
            now_ff <= req_data.now_us;
            if (!armed_ff) begin
               next_rpt_ff <= req_data.now_us + TIME_BITS'(interval_ff);
               armed_ff    <= 1'b1;
            end
            if (req_data.req_type == REQ_PROBE) begin
               if (sent_ff != COUNT_MAX) begin
                  sent_ff <= sent_ff + 1'b1;
               end
            end else if (req_data.req_type == REQ_REPLY) begin
               prev_ff <= d_new;
               d_ff    <= d_new;
               j_ff    <= j_new;
               if (rcvd_ff != COUNT_MAX) begin
                  rcvd_ff  <= rcvd_ff + 1'b1;
                  dtot_ff  <= dtot_ff + SUM_BITS'(d_new);
                  jtot_ff  <= jtot_ff + SUM_BITS'(j_new);
                  sq_ok_ff <= 1'b1;
               end else begin
                  sq_ok_ff <= 1'b0;
               end
            end
         end

         // Result capture from the unit.
         if (res.done) begin
            unique case (state_ff)
               ST_SQD:   if (sq_ok_ff) dsq_ff <= sq_sum[SQ_BITS] ? '1 : sq_sum[SQ_BITS-1:0];
               ST_SQJ:   if (sq_ok_ff) jsq_ff <= sq_sum[SQ_BITS] ? '1 : sq_sum[SQ_BITS-1:0];
               ST_DMEAN: dm_ff <= res.result[DELAY_BITS-1:0];
               ST_DNS2, ST_JMS2: prod_ff <= res.result;
               ST_DS1S1: begin
                  if (res_le_prod) begin
                     prod_ff <= prod_ff - res.result;
                  end else begin
                     dd_ff <= '0;
                  end
               end
               ST_JS1S1: prod_ff <= res_le_prod ? prod_ff - res.result
                                                : res.result - prod_ff;
               ST_DSQRT, ST_JSQRT: root_ff <= res.result[63:0];
               ST_DDEV:  dd_ff <= (|res.result[63:22]) ? DEV_MAX : res.result[21:0];
               ST_JMEAN: jm_ff <= res.result[41:0];
               ST_JDEV:  jd_ff <= (|res.result[63:22]) ? DEV_MAX : res.result[21:0];
               ST_LOSS:  loss_ff <= res.result[13:0];
               default:  loss_ff <= loss_ff;
            endcase
         end

         // Report due with an empty window: zero statistics.
         if (state_ff == ST_CHECK && due && rcvd_ff == '0) begin
            dm_ff <= '0;
            dd_ff <= '0;
            jm_ff <= '0;
            jd_ff <= '0;
         end

         if (state_ff == ST_LOSS && !need_loss) begin
            loss_ff <= '0;
         end

         // Report: load the output register, roll totals and clear the window.
         if (state_ff == ST_DONE && load_ok) begin
            rsp_valid_ff               <= 1'b1;
            rsp_data_ff.delay_mean     <= dm_ff;
            rsp_data_ff.delay_dev      <= dd_ff;
            rsp_data_ff.jitter_mean    <= jm_ff;
            rsp_data_ff.jitter_dev     <= jd_ff;
            rsp_data_ff.loss_centi_pct <= loss_ff;
            rsp_data_ff.window_bits    <= {win_bytes[35:0], 3'b000};
            rsp_data_ff.window_sent    <= sent_ff;
            rsp_data_ff.window_rcvd    <= rcvd_ff;
            rsp_data_ff.running_sent   <= sent_grand_ff + 32'(sent_ff);
            rsp_data_ff.running_rcvd   <= rcvd_grand_ff + 32'(rcvd_ff);
            sent_grand_ff              <= sent_grand_ff + 32'(sent_ff);
            rcvd_grand_ff              <= rcvd_grand_ff + 32'(rcvd_ff);
            sent_ff                    <= '0;
            rcvd_ff                    <= '0;
            dtot_ff                    <= '0;
            jtot_ff                    <= '0;
            dsq_ff                     <= '0;
            jsq_ff                     <= '0;
            next_rpt_ff                <= now_ff + TIME_BITS'(interval_ff);
         end
      end
   end

   assign req_stall = (state_ff != ST_IDLE);
   assign csr_ready = (state_ff == ST_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule

// ===== test/dljs_scoreboard.sv =====
// Statistics predictor and result checker for the delay, jitter and loss core.
// Depends on dljs_pkg for the transaction structs, limits and request codes.
class dljs_scoreboard;

   // Register copies.
   logic [15:0] payload_bytes;
   logic [31:0] report_interval;

   // Window and running state.
   logic [19:0]  sent_count;
   logic [19:0]  rcvd_count;
   logic [63:0]  delay_sum;
   logic [63:0]  delay_sq_sum;
   logic [63:0]  jitter_sum;
   logic [63:0]  jitter_sq_sum;
   logic [21:0]  last_delay;
   logic [47:0]  report_due;
   bit           armed;
   logic [31:0]  sent_total;
   logic [31:0]  rcvd_total;

   dljs_pkg::dljs_rsp_type pending_reports[$];
   int unsigned            failures;

   function new();
      failures = 0;
      clear();
   endfunction

   function void clear();
      payload_bytes   = dljs_pkg::PAYLOAD_RESET;
      report_interval = dljs_pkg::INTERVAL_RESET;
      sent_count = '0;
      rcvd_count = '0;
      delay_sum = '0;
      delay_sq_sum = '0;
      jitter_sum = '0;
      jitter_sq_sum = '0;
      last_delay = '0;
      report_due = '0;
      armed = 0;
      sent_total = '0;
      rcvd_total = '0;
      pending_reports.delete();
   endfunction

   function void write_register(logic idx, logic [31:0] value);
      if (idx == dljs_pkg::CSR_PAYLOAD_BYTES) payload_bytes = value[15:0];
      else report_interval = value;
   endfunction

   // Bit-by-bit integer square root of a 128-bit value.
   function logic [63:0] isqrt(logic [127:0] x);
      logic [63:0]  r;
      logic [63:0]  t;
      logic [127:0] sq;
      r = '0;
      for (int b = 63; b >= 0; b--) begin
         t = r | (64'd1 << b);
         sq = 128'(t) * 128'(t);
         if (sq <= x) r = t;
      end
      return r;
   endfunction

   // floor(sqrt(m*s2 - s1^2) / m); a negative radicand is clamped or mirrored.
   function logic [63:0] spread(logic [63:0] m, logic [63:0] s1, logic [63:0] s2,
                                bit mirror);
      logic [127:0] a;
      logic [127:0] b;
      logic [127:0] d;
      a = 128'(m) * 128'(s2);
      b = 128'(s1) * 128'(s1);
      if (b <= a) d = a - b;
      else if (mirror) d = b - a;
      else return 64'd0;
      return isqrt(d) / m;
   endfunction

   function logic [63:0] sat_sum(logic [63:0] a, logic [63:0] b);
      logic [64:0] s;
      s = {1'b0, a} + {1'b0, b};
      return s[64] ? {64{1'b1}} : s[63:0];
   endfunction

   // Note one accepted request transaction and queue any report it causes.
   function void note_request(dljs_pkg::dljs_req_type req);
      logic [47:0] trip;
      logic [47:0] gap;
      logic [21:0] d;
      logic [21:0] j;
      logic [63:0] n;
      logic [63:0] m;
      logic [63:0] dev;
      dljs_pkg::dljs_rsp_type r;
      if (!armed) begin
         report_due = req.now_us + 48'(report_interval);
         armed = 1;
      end
      if (req.req_type == dljs_pkg::REQ_PROBE) begin
         if (sent_count != dljs_pkg::COUNT_MAX) sent_count++;
      end else if (req.req_type == dljs_pkg::REQ_REPLY) begin
         trip = req.now_us - req.stamp_us;
         d = (trip > 48'(dljs_pkg::DELAY_MAX)) ? dljs_pkg::DELAY_MAX : trip[21:0];
         j = (d >= last_delay) ? d - last_delay : last_delay - d;
         if (rcvd_count != dljs_pkg::COUNT_MAX) begin
            rcvd_count++;
            delay_sum += 64'(d);
            delay_sq_sum = sat_sum(delay_sq_sum, 64'(d) * 64'(d));
            jitter_sum += 64'(j);
            jitter_sq_sum = sat_sum(jitter_sq_sum, 64'(j) * 64'(j));
         end
         last_delay = d;
      end
      gap = req.now_us - report_due;
      if (gap[47]) return;

      r = '0;
      n = 64'(rcvd_count);
      if (n != 0) begin
         m = (n >= 2) ? n - 1 : 64'd1;
         r.delay_mean = 22'(delay_sum / n);
         dev = spread(n, delay_sum, delay_sq_sum, 0);
         r.delay_dev = (dev > 64'(dljs_pkg::DEV_MAX)) ? dljs_pkg::DEV_MAX : dev[21:0];
         r.jitter_mean = 42'(jitter_sum / m);
         dev = spread(m, jitter_sum, jitter_sq_sum, 1);
         r.jitter_dev = (dev > 64'(dljs_pkg::DEV_MAX)) ? dljs_pkg::DEV_MAX : dev[21:0];
      end
      if (sent_count != 0 && sent_count > rcvd_count)
         r.loss_centi_pct = 14'((64'd10000 * 64'(sent_count - rcvd_count)) /
                                64'(sent_count));
      sent_total += 32'(sent_count);
      rcvd_total += 32'(rcvd_count);
      r.window_bits  = 39'(64'(payload_bytes) * n * 64'd8);
      r.window_sent  = sent_count;
      r.window_rcvd  = rcvd_count;
      r.running_sent = sent_total;
      r.running_rcvd = rcvd_total;
      pending_reports.push_back(r);

      sent_count = '0;
      rcvd_count = '0;
      delay_sum = '0;
      delay_sq_sum = '0;
      jitter_sum = '0;
      jitter_sq_sum = '0;
      report_due = req.now_us + 48'(report_interval);
   endfunction

   // Compare one accepted report with the oldest expectation.
   function void check_report(dljs_pkg::dljs_rsp_type got);
      dljs_pkg::dljs_rsp_type want;
      if (pending_reports.size() == 0) begin
         $display("%0t: unexpected report %h", $time, got);
         failures++;
         return;
      end
      want = pending_reports.pop_front();
      if (got.delay_mean !== want.delay_mean)
         $display("%0t: delay_mean exp %0d got %0d", $time, want.delay_mean, got.delay_mean);
      if (got.delay_dev !== want.delay_dev)
         $display("%0t: delay_dev exp %0d got %0d", $time, want.delay_dev, got.delay_dev);
      if (got.jitter_mean !== want.jitter_mean)
         $display("%0t: jitter_mean exp %0d got %0d", $time, want.jitter_mean,
                  got.jitter_mean);
      if (got.jitter_dev !== want.jitter_dev)
         $display("%0t: jitter_dev exp %0d got %0d", $time, want.jitter_dev, got.jitter_dev);
      if (got.loss_centi_pct !== want.loss_centi_pct)
         $display("%0t: loss exp %0d got %0d", $time, want.loss_centi_pct,
                  got.loss_centi_pct);
      if (got.window_bits !== want.window_bits)
         $display("%0t: window_bits exp %0d got %0d", $time, want.window_bits,
                  got.window_bits);
      if (got.window_sent !== want.window_sent)
         $display("%0t: window_sent exp %0d got %0d", $time, want.window_sent,
                  got.window_sent);
      if (got.window_rcvd !== want.window_rcvd)
         $display("%0t: window_rcvd exp %0d got %0d", $time, want.window_rcvd,
                  got.window_rcvd);
      if (got.running_sent !== want.running_sent)
         $display("%0t: running_sent exp %0d got %0d", $time, want.running_sent,
                  got.running_sent);
      if (got.running_rcvd !== want.running_rcvd)
         $display("%0t: running_rcvd exp %0d got %0d", $time, want.running_rcvd,
                  got.running_rcvd);
      if (got !== want) failures++;
   endfunction

endclass

// ===== test/delay_jitter_loss_statistics_core_test.sv =====
// Top-level testbench: drives requests and register writes, checks every report.
// Depends on dljs_pkg, dljs_scoreboard and delay_jitter_loss_statistics_core.
module delay_jitter_loss_statistics_core_test;
   import dljs_pkg::*;

   timeunit 1ns;
   timeprecision 1ps;

   localparam int WATCHDOG_LIMIT = 20000;

   logic         clock = 0;
   logic         reset = 1;
   logic         req_valid = 0;
   logic         req_stall;
   dljs_req_type req_data = '0;
   logic         rsp_valid;
   logic         rsp_stall = 0;
   dljs_rsp_type rsp_data;
   logic         csr_valid = 0;
   logic         csr_ready;
   logic         csr_index = 0;
   logic [31:0]  csr_wdata = '0;

   dljs_scoreboard stats = new();
   int          send_idle_pct = 0;
   int          recv_idle_pct = 0;
   int unsigned quiet_cycles = 0;
   logic [47:0] clock_us = '0;

   delay_jitter_loss_statistics_core uut (.*);

   always #2 clock = ~clock;

   // Receiver side: random stall, check each accepted report.
   always @(posedge clock) begin
      if (!reset) begin
         if (rsp_valid && !rsp_stall) stats.check_report(rsp_data);
         rsp_stall <= ($urandom_range(99) < recv_idle_pct);
      end
   end

   // Watchdog on cycles with no transaction anywhere.
   always @(posedge clock) begin
      if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall) || (csr_valid && csr_ready)
          || reset)
         quiet_cycles <= 0;
      else
         quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
         $display("delay_jitter_loss_statistics_core_test NOT OK");
         $finish;
      end
   end

   // Send one request transaction, with an optional idle gap before it. The core stalls
   // in the cycle after an acceptance, so the closing edge costs no throughput.
   task automatic send(logic [1:0] kind, logic [47:0] now, logic [47:0] stamp);
      while ($urandom_range(99) < send_idle_pct) @(posedge clock);
      req_valid <= 1;
      req_data  <= '{req_type: kind, now_us: now, stamp_us: stamp};
      do @(posedge clock); while (req_stall);
      stats.note_request('{req_type: kind, now_us: now, stamp_us: stamp});
      req_valid <= 0;
      @(posedge clock);
   endtask

   // Wait until every report has come, plus room for the longest report pass.
   task automatic drain();
      while (stats.pending_reports.size() != 0) @(posedge clock);
      repeat (1000) @(posedge clock);
   endtask

   task automatic write_csr(logic idx, logic [31:0] value);
      csr_valid <= 1;
      csr_index <= idx;
      csr_wdata <= value;
      do @(posedge clock); while (!csr_ready);
      stats.write_register(idx, value);
      csr_valid <= 0;
      @(posedge clock);
   endtask

   // A random probe, reply or poll; replies use short, mid, saturating or huge round trips.
   task automatic random_item();
      logic [47:0] trip;
      int          pick;
      pick = $urandom_range(99);
      clock_us = clock_us + 48'($urandom_range(3000));
      if (pick < 35) begin
         send(REQ_PROBE, clock_us, 48'({$urandom, $urandom}));
      end else if (pick < 85) begin
         case ($urandom_range(3))
            0: trip = 48'($urandom_range(200));
            1: trip = 48'($urandom_range(4194303));
            2: trip = 48'(DELAY_MAX) + 48'($urandom_range(1));
            default: trip = 48'({$urandom, $urandom});
         endcase
         send(REQ_REPLY, clock_us, clock_us - trip);
      end else begin
         send(2'($urandom_range(2, 3)), clock_us, 48'({$urandom, $urandom}));
      end
   endtask

   task automatic random_phase(int items, int sender, int receiver);
      send_idle_pct = sender;
      recv_idle_pct = receiver;
      repeat (items) random_item();
   endtask

   initial begin
      repeat (4) @(posedge clock);
      reset <= 0;
      @(posedge clock);

      // Directed: field extremes, every request code, stamp after now, wrap of time.
      send(REQ_PROBE, 48'd0, '1);
      send(REQ_REPLY, 48'd10, 48'd0);
      send(REQ_REPLY, 48'd500, 48'd400);
      send(REQ_REPLY, 48'd600, 48'd700);
      send(REQ_REPLY, '1, 48'd0);
      send(REQ_REPLY, 48'd1000, 48'd1000);
      send(2'd2, 48'd1000, '1);
      send(2'd3, 48'd1000000, 48'd0);
      send(REQ_PROBE, 48'd1100000, 48'd0);
      send(2'd2, 48'd3000000, 48'd0);
      send(2'd2, '1, '1);
      send(REQ_PROBE, 48'd5, 48'd0);
      drain();

      // Extreme register settings: interval 0 reports on every item at or after the report time.
      write_csr(CSR_PAYLOAD_BYTES, 32'hFFFF);
      write_csr(CSR_REPORT_INTERVAL, 32'd0);
      send(REQ_REPLY, 48'd2000, 48'd1000);
      send(REQ_PROBE, 48'd2001, 48'd0);
      send(REQ_REPLY, 48'h800000000000, 48'h7FFFFFFFFFFF);
      send(2'd2, 48'd7, 48'd0);
      drain();
      write_csr(CSR_PAYLOAD_BYTES, 32'd1);
      write_csr(CSR_REPORT_INTERVAL, 32'hFFFFFFFF);
      send(REQ_REPLY, 48'd10, 48'd3);
      send(2'd2, 48'h100000000, 48'd0);
      drain();

      // Random phases with short reporting intervals so reports are frequent.
      write_csr(CSR_PAYLOAD_BYTES, 32'd1472);
      write_csr(CSR_REPORT_INTERVAL, 32'd10000);
      clock_us = 48'h0000FFFFF000;
      random_phase(280, 6, 82);
      drain();
      // A poll half the time range on moves the report time, so the next phase reports
      // from its first item and then runs across the wrap of time.
      write_csr(CSR_PAYLOAD_BYTES, 32'($urandom_range(65535)));
      write_csr(CSR_REPORT_INTERVAL, 32'd20000);
      send(2'd2, 48'h7FFFFFFC0000, 48'd0);
      clock_us = 48'hFFFFFFFC0000;
      random_phase(280, 82, 6);
      drain();
      write_csr(CSR_PAYLOAD_BYTES, 32'd64);
      write_csr(CSR_REPORT_INTERVAL, 32'd15000);
      random_phase(290, 0, 0);
      drain();

      if (stats.failures == 0)
         $display("delay_jitter_loss_statistics_core_test OK");
      else
         $display("delay_jitter_loss_statistics_core_test NOT OK");
      $finish;
   end

endmodule
